>>> rtl/core/assert_macros.svh
// assertion macros shared by the rtl
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`endif

>>> rtl/core/lasa_pkg.sv
// package for the local alignment statistics block
// types and constants; no dependencies
`timescale 1ns / 1ps
`default_nettype none
package lasa_pkg;
  localparam int unsigned MaxQueryDef  = 1024;
  localparam int unsigned ScoreBitsDef = 16;
  localparam int unsigned AlphabetDef  = 32;

  typedef enum logic [1:0] {
    OP_TABLE  = 2'd0,
    OP_APPEND = 2'd1,
    OP_DB     = 2'd2,
    OP_CLEAR  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CFG_GAP_OPEN = 2'd0,
    CFG_GAP_EXT  = 2'd1,
    CFG_NEG_LIM  = 2'd2,
    CFG_POS_LIM  = 2'd3
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_READ,
    ST_CELL,
    ST_DONE,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic [4:0]        residue;
    logic [4:0]        table_row;
    logic [4:0]        table_col;
    logic signed [7:0] table_value;
    logic              last;
  } in_item_t;

  typedef struct packed {
    logic [14:0] score;
    logic [14:0] matches_res;
    logic [14:0] similar;
    logic [14:0] align_length;
    logic [9:0]  end_qpos;
    logic [15:0] end_ref;
    logic        saturated;
  } out_item_t;

  typedef struct packed {
    logic [1:0]  cfg_idx;
    logic [15:0] cfg_data;
  } cfg_req_t;
endpackage
`default_nettype wire

>>> rtl/core/lasa_ram.sv
// generic single-port-write ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
module lasa_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

>>> rtl/core/lasa_cell.sv
// one dynamic-programming cell update: gap choices, max, count paths
// depends on lasa_pkg
`timescale 1ns / 1ps
`default_nettype none
module lasa_cell import lasa_pkg::*; #(
  parameter int unsigned ScoreBits = ScoreBitsDef
) (
  input  wire logic [7:0]                  gap_open_i,
  input  wire logic [7:0]                  gap_ext_i,
  input  wire logic signed [ScoreBits-1:0] neg_i,
  input  wire logic signed [ScoreBits+1:0] neg_full_i,
  input  wire logic [14:0]                 pos_i,
  input  wire logic signed [7:0]           mat_i,
  input  wire logic                        ident_i,
  // up (h of previous row), f, diagonal, left (col), e
  input  wire logic signed [ScoreBits-1:0] u_h_i, u_m_i, u_s_i, u_l_i,
  input  wire logic signed [ScoreBits-1:0] f_h_i, f_m_i, f_s_i, f_l_i,
  input  wire logic signed [ScoreBits-1:0] d_h_i, d_m_i, d_s_i, d_l_i,
  input  wire logic signed [ScoreBits-1:0] l_h_i, l_m_i, l_s_i, l_l_i,
  input  wire logic signed [ScoreBits-1:0] e_h_i, e_m_i, e_s_i, e_l_i,
  output logic signed [ScoreBits-1:0]      h_o, hm_o, hs_o, hl_o,
  output logic signed [ScoreBits-1:0]      nf_h_o, nf_m_o, nf_s_o, nf_l_o,
  output logic signed [ScoreBits-1:0]      ne_h_o, ne_m_o, ne_s_o, ne_l_o,
  output logic                             ovf_o
);
  localparam int unsigned W = ScoreBits + 2;
  localparam logic signed [W-1:0] Hi = W'((1 << (ScoreBits - 1)) - 1);
  localparam logic signed [W-1:0] Lo = -Hi - W'(1);

  function automatic logic signed [ScoreBits-1:0] hold(input logic signed [W-1:0] v);
    if (v < Lo) hold = Lo[ScoreBits-1:0];
    else if (v > Hi) hold = Hi[ScoreBits-1:0];
    else hold = v[ScoreBits-1:0];
  endfunction

  logic signed [W-1:0] go, ge, fop, fex, eop, eex, fh, el, fl, eh, dg, h, pl;
  logic signed [W-1:0] hm, hs, hl;
  logic signed [ScoreBits-1:0] fhh, ehh;

  always_comb begin
    go  = W'($signed({1'b0, gap_open_i}));
    ge  = W'($signed({1'b0, gap_ext_i}));
    pl  = W'($signed({1'b0, pos_i}));
    fop = W'(u_h_i) - go;
    fex = W'(f_h_i) - ge;
    if (fop > fex) begin
      fh = fop; nf_m_o = u_m_i; nf_s_o = u_s_i; fl = W'(u_l_i);
    end else begin
      fh = fex; nf_m_o = f_m_i; nf_s_o = f_s_i; fl = W'(f_l_i);
    end
    fhh = hold(fh);
    nf_h_o = fhh;
    nf_l_o = hold(fl + W'(1));
    eop = W'(l_h_i) - go;
    eex = W'(e_h_i) - ge;
    if (eop > eex) begin
      eh = eop; ne_m_o = l_m_i; ne_s_o = l_s_i; el = W'(l_l_i);
    end else begin
      eh = eex; ne_m_o = e_m_i; ne_s_o = e_s_i; el = W'(e_l_i);
    end
    ehh = hold(eh);
    ne_h_o = ehh;
    ne_l_o = hold(el + W'(1));
    dg = W'(d_h_i) + W'(mat_i);
    h = dg;
    if (W'(ehh) > h) h = W'(ehh);
    if (W'(fhh) > h) h = W'(fhh);
    if (h < 0) h = '0;
    if (h == 0) begin
      hm = '0; hs = '0; hl = '0;
    end else if (h == dg) begin
      hm = W'(d_m_i) + W'(ident_i);
      hs = W'(d_s_i) + W'(mat_i > 0);
      hl = W'(d_l_i) + W'(1);
    end else if (h == W'(fhh)) begin
      hm = W'(nf_m_o); hs = W'(nf_s_o); hl = W'(nf_l_o);
    end else begin
      hm = W'(ne_m_o); hs = W'(ne_s_o); hl = W'(ne_l_o);
    end
    ovf_o = (h < neg_full_i) || (h > pl) || (hm > pl) || (hs > pl) || (hl > pl);
    h_o  = hold(h);
    hm_o = hold(hm);
    hs_o = hold(hs);
    hl_o = hold(hl);
  end
  logic unused_neg;
  assign unused_neg = ^neg_i;
endmodule
`default_nettype wire

>>> rtl/core/local_alignment_stats_affine.sv
// sequencing: a database request passes from accept through decode, then a query
// and column read, table read and cell update per query row, then wrap-up before
// the next accept; other requests pass through decode only; a job's first database
// request adds a column init sweep over all MaxQuery column entries
// throughput: one request at a time, column memories have one read and one write port each
// reset: asynchronous active low, clears control, config to defaults
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module local_alignment_stats_affine import lasa_pkg::*; #(
  parameter int unsigned MaxQuery  = MaxQueryDef,
  parameter int unsigned ScoreBits = ScoreBitsDef,
  parameter int unsigned Alphabet  = AlphabetDef
) (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  input  wire in_item_t  in_data_i,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output out_item_t      out_data_o,
  input  wire logic      cfg_valid_i,
  output logic           cfg_ready_o,
  input  wire cfg_req_t  cfg_data_i
);
  localparam int unsigned QA = (MaxQuery > 1) ? $clog2(MaxQuery) : 1;
  localparam int unsigned QC = $clog2(MaxQuery + 1);
  localparam int unsigned SB = ScoreBits;
  localparam int unsigned CW = 4 * SB;       // one column record: h m s l
  localparam int unsigned TA = 10;           // table address row, col

  typedef logic signed [SB-1:0] sv_t;

  // configuration registers
  logic [7:0]  gap_open_q, gap_ext_q;
  logic [15:0] neg_lim_q;
  logic [14:0] pos_lim_q;

  state_e state_q, state_d;
  in_item_t req_q;
  logic [QC-1:0] qcount_q;
  logic [QA-1:0] idx_q;
  logic [15:0] refpos_q;
  logic job_open_q, ovf_q;
  logic [QC-1:0] init_q;

  // running up / f / diagonal values
  sv_t u_h_q, u_m_q, u_s_q, u_l_q;
  sv_t f_h_q, f_m_q, f_s_q, f_l_q;
  sv_t d_h_q, d_m_q, d_s_q, d_l_q;
  // best record
  logic signed [16:0] best_h_q;
  sv_t best_m_q, best_s_q, best_l_q;
  logic [QA-1:0] best_q_q;
  logic [15:0] best_r_q;
  out_item_t out_q;
  logic out_valid_q;

  // neg limit held to storage width
  logic signed [15:0] neg_s;
  sv_t neg_held;
  always_comb begin
    neg_s = $signed(neg_lim_q);
    if (SB >= 16) neg_held = SB'(neg_s);
    else if (neg_s < -(17'sd1 <<< (SB - 1))) neg_held = {1'b1, {(SB-1){1'b0}}};
    else neg_held = neg_s[SB-1:0];
  end

  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gap_open_q <= 8'd10;
      gap_ext_q  <= 8'd1;
      neg_lim_q  <= 16'hFFFF - 16'd31999;
      pos_lim_q  <= 15'd32000;
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_data_i.cfg_idx))
        CFG_GAP_OPEN: gap_open_q <= cfg_data_i.cfg_data[7:0];
        CFG_GAP_EXT:  gap_ext_q  <= cfg_data_i.cfg_data[7:0];
        CFG_NEG_LIM:  neg_lim_q  <= cfg_data_i.cfg_data;
        CFG_POS_LIM:  pos_lim_q  <= cfg_data_i.cfg_data[14:0];
        default: ;
      endcase
    end
  end

  // memories
  logic          q_we;
  logic [QA-1:0] q_raddr;
  logic [4:0]    q_rdata;
  lasa_ram #(.Width(5), .Depth(MaxQuery)) u_query (
    .clk_i, .we_i(q_we), .waddr_i(qcount_q[QA-1:0]), .wdata_i(req_q.residue),
    .raddr_i(q_raddr), .rdata_o(q_rdata)
  );

  logic          t_we;
  logic [7:0]    t_rdata;
  lasa_ram #(.Width(8), .Depth(1 << TA)) u_subst (
    .clk_i, .we_i(t_we), .waddr_i({req_q.table_row, req_q.table_col}),
    .wdata_i(req_q.table_value), .raddr_i({q_rdata, req_q.residue}), .rdata_o(t_rdata)
  );

  logic          c_we;
  logic [QA-1:0] c_waddr;
  logic [CW-1:0] col_wdata, col_rdata, gap_wdata, gap_rdata;
  lasa_ram #(.Width(CW), .Depth(MaxQuery)) u_col (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(col_wdata),
    .raddr_i(q_raddr), .rdata_o(col_rdata)
  );
  lasa_ram #(.Width(CW), .Depth(MaxQuery)) u_gap (
    .clk_i, .we_i(c_we), .waddr_i(c_waddr), .wdata_i(gap_wdata),
    .raddr_i(q_raddr), .rdata_o(gap_rdata)
  );

  // ST_READ phase 0 addresses the query and column rams, phase 1
  // captures them and addresses the table with the query residue, then
  // ST_CELL updates the cell
  logic [1:0] phase_q;
  logic [4:0] qres_q;
  logic [CW-1:0] col_q, gap_q;

  sv_t h_w, hm_w, hs_w, hl_w, nfh, nfm, nfs, nfl, neh, nem, nes, nel;
  logic ovf_w;
  lasa_cell #(.ScoreBits(SB)) u_cell (
    .gap_open_i(gap_open_q), .gap_ext_i(gap_ext_q), .neg_i(neg_held),
    .neg_full_i((SB+2)'($signed(neg_lim_q))), .pos_i(pos_lim_q),
    .mat_i(({1'b0, qres_q} < 6'(Alphabet) && {1'b0, req_q.residue} < 6'(Alphabet))
           ? $signed(t_rdata) : 8'sd0),
    .ident_i(qres_q == req_q.residue),
    .u_h_i(u_h_q), .u_m_i(u_m_q), .u_s_i(u_s_q), .u_l_i(u_l_q),
    .f_h_i(f_h_q), .f_m_i(f_m_q), .f_s_i(f_s_q), .f_l_i(f_l_q),
    .d_h_i(d_h_q), .d_m_i(d_m_q), .d_s_i(d_s_q), .d_l_i(d_l_q),
    .l_h_i(col_q[4*SB-1:3*SB]), .l_m_i(col_q[3*SB-1:2*SB]),
    .l_s_i(col_q[2*SB-1:SB]), .l_l_i(col_q[SB-1:0]),
    .e_h_i(gap_q[4*SB-1:3*SB]), .e_m_i(gap_q[3*SB-1:2*SB]),
    .e_s_i(gap_q[2*SB-1:SB]), .e_l_i(gap_q[SB-1:0]),
    .h_o(h_w), .hm_o(hm_w), .hs_o(hs_w), .hl_o(hl_w),
    .nf_h_o(nfh), .nf_m_o(nfm), .nf_s_o(nfs), .nf_l_o(nfl),
    .ne_h_o(neh), .ne_m_o(nem), .ne_s_o(nes), .ne_l_o(nel),
    .ovf_o(ovf_w)
  );

  logic last_cell;
  assign last_cell = ({1'b0, idx_q} == (QA+1)'(qcount_q - QC'(1)));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_DONE;
      // an empty query still closes the column after the init sweep
      ST_INIT: if (init_q == QC'(MaxQuery - 1)) state_d = (qcount_q == '0) ? ST_OUT : ST_READ;
      ST_READ: if (phase_q == 2'd1) state_d = ST_CELL;
      ST_CELL: state_d = last_cell ? ST_OUT : ST_READ;
      ST_DONE: begin
        if (opcode_e'(req_q.opcode) == OP_DB) begin
          if (!job_open_q) state_d = ST_INIT;
          else if (qcount_q == '0) state_d = ST_OUT;
          else state_d = ST_READ;
        end else state_d = ST_IDLE;
      end
      ST_OUT: if (!out_valid_q) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = (state_q == ST_IDLE);
    q_we = (state_q == ST_DONE) && (opcode_e'(req_q.opcode) == OP_APPEND)
           && (qcount_q < QC'(MaxQuery));
    t_we = (state_q == ST_DONE) && (opcode_e'(req_q.opcode) == OP_TABLE)
           && ({1'b0, req_q.table_row} < 6'(Alphabet))
           && ({1'b0, req_q.table_col} < 6'(Alphabet));
    q_raddr = idx_q;
    c_we = 1'b0;
    c_waddr = idx_q;
    col_wdata = {h_w, hm_w, hs_w, hl_w};
    gap_wdata = {neh, nem, nes, nel};
    if (state_q == ST_INIT) begin
      c_we = 1'b1;
      c_waddr = init_q[QA-1:0];
      col_wdata = '0;
      gap_wdata = {neg_held, {(3*SB){1'b0}}};
    end else if (state_q == ST_CELL) c_we = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) req_q <= in_data_i;
    if (state_q == ST_READ && phase_q == 2'd1) qres_q <= q_rdata;
    if (state_q == ST_READ && phase_q == 2'd1) col_q <= col_rdata;
    if (state_q == ST_READ && phase_q == 2'd1) gap_q <= gap_rdata;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      qcount_q <= '0;
      idx_q <= '0;
      refpos_q <= '0;
      job_open_q <= 1'b0;
      ovf_q <= 1'b0;
      init_q <= '0;
      phase_q <= '0;
      out_valid_q <= 1'b0;
      out_q <= '0;
      {u_h_q, u_m_q, u_s_q, u_l_q} <= '0;
      {f_h_q, f_m_q, f_s_q, f_l_q} <= '0;
      {d_h_q, d_m_q, d_s_q, d_l_q} <= '0;
      best_h_q <= '0;
      {best_m_q, best_s_q, best_l_q} <= '0;
      best_q_q <= '0;
      best_r_q <= '0;
    end else begin
      state_q <= state_d;
      if (out_valid_q && out_ready_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_IDLE: ;
        ST_DONE: begin
          init_q <= '0;
          idx_q <= '0;
          phase_q <= '0;
          {u_h_q, u_m_q, u_s_q, u_l_q} <= '0;
          {f_m_q, f_s_q, f_l_q} <= '0;
          f_h_q <= SB'($signed(neg_lim_q));
          {d_h_q, d_m_q, d_s_q, d_l_q} <= '0;
          unique case (opcode_e'(req_q.opcode))
            OP_APPEND: if (qcount_q < QC'(MaxQuery)) qcount_q <= qcount_q + QC'(1);
            OP_CLEAR:  qcount_q <= '0;
            OP_DB: if (!job_open_q) begin
              job_open_q <= 1'b1;
              ovf_q <= 1'b0;
              refpos_q <= '0;
              best_h_q <= 17'($signed(neg_lim_q));
              {best_m_q, best_s_q, best_l_q} <= '0;
              best_q_q <= '0;
              best_r_q <= '0;
            end
            default: ;
          endcase
        end
        ST_INIT: init_q <= init_q + QC'(1);
        ST_READ: phase_q <= phase_q + 2'd1;
        ST_CELL: begin
          phase_q <= '0;
          idx_q <= idx_q + QA'(1);
          {u_h_q, u_m_q, u_s_q, u_l_q} <= {h_w, hm_w, hs_w, hl_w};
          {f_h_q, f_m_q, f_s_q, f_l_q} <= {nfh, nfm, nfs, nfl};
          {d_h_q, d_m_q, d_s_q, d_l_q} <= col_q;
          if (ovf_w) ovf_q <= 1'b1;
          if (17'(h_w) > best_h_q) begin
            best_h_q <= 17'(h_w);
            best_m_q <= hm_w; best_s_q <= hs_w; best_l_q <= hl_w;
            best_q_q <= idx_q;
            best_r_q <= refpos_q;
          end
        end
        ST_OUT: if (!out_valid_q) begin
          refpos_q <= refpos_q + 16'd1;
          if (req_q.last) begin
            job_open_q <= 1'b0;
            out_valid_q <= 1'b1;
            if (ovf_q) begin
              out_q <= '{saturated: 1'b1, default: '0};
            end else begin
              out_q.score <= (best_h_q > 0) ? best_h_q[14:0] : '0;
              out_q.matches_res <= (best_m_q > 0) ? 15'(best_m_q) : '0;
              out_q.similar <= (best_s_q > 0) ? 15'(best_s_q) : '0;
              out_q.align_length <= (best_l_q > 0) ? 15'(best_l_q) : '0;
              out_q.end_qpos <= 10'(best_q_q);
              out_q.end_ref <= best_r_q;
              out_q.saturated <= 1'b0;
            end
          end
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `ASSERT_IMPL(a_ready_idle, clk_i, rst_ni, in_ready_o, state_q == ST_IDLE && !q_we, "ready outside idle")
  `ASSERT_IMPL(a_cell_bound, clk_i, rst_ni, state_q == ST_CELL, QC'(idx_q) < qcount_q, "cell beyond query")
  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o && $stable(out_data_o), "result dropped")
endmodule
`default_nettype wire
